@@ design/double_fmod_shift_subtract_macros.svh @@
// Assertion macros for the double fmod block.
// Included by the top level; no other dependencies.
`ifndef DOUBLE_FMOD_SHIFT_SUBTRACT_MACROS_SVH
`define DOUBLE_FMOD_SHIFT_SUBTRACT_MACROS_SVH
`ifndef SYNTH
`define DFM_ASSERT_IMPL(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("dfm check");
`define DFM_ASSERT_NEXT(label, clk, rst_n, a, c) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("dfm check");
`else
`define DFM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DFM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ design/dfm_pkg.sv @@
// Package for the double fmod block: payload structs, constants, states.
// No dependencies.
`timescale 1ns / 1ps
package dfm_pkg;
    localparam logic [63:0] QNAN_BITS  = 64'h7FF8000000000000;
    localparam logic [62:0] EXP_INF    = 63'h7FF0000000000000;
    localparam int          QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [63:0] dividend_bits;
        logic [63:0] divisor_bits;
    } dfm_in_t;

    typedef struct packed {
        logic [63:0] remainder_bits;
        logic        invalid_op;
    } dfm_out_t;

    // Classified job between front and back
    typedef struct packed {
        logic        direct;      // result already known
        logic [63:0] direct_bits;
        logic        invalid;
        logic        sign;
        logic [52:0] mx;
        logic [52:0] my;
        logic [11:0] ex;          // biased exponent field (>=1)
        logic [11:0] ey;
    } dfm_job_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_REDUCE, ST_RENORM, ST_PACK, ST_DONE
    } dfm_state_t;
endpackage

@@ design/dfm_front.sv @@
// Front end: accepts a word, classifies special cases, unpacks operands.
// Depends on dfm_pkg.
`timescale 1ns / 1ps
module dfm_front (
    input  logic             start,
    input  dfm_pkg::dfm_in_t operands,
    input  logic             q_full,
    output logic             busy,
    output logic             push,
    output dfm_pkg::dfm_job_t job
);
    import dfm_pkg::*;

    logic [62:0] ax, ay;
    logic        sx;

    assign busy = q_full;
    assign push = start && !q_full;
    assign ax   = operands.dividend_bits[62:0];
    assign ay   = operands.divisor_bits[62:0];
    assign sx   = operands.dividend_bits[63];

    // Special case classification and raw unpack
    always_comb
    begin
        job = '0;
        job.sign = sx;
        job.mx = {(ax[62:52] != 11'd0), ax[51:0]};
        job.my = {(ay[62:52] != 11'd0), ay[51:0]};
        job.ex = (ax[62:52] == 11'd0) ? 12'd1 : {1'b0, ax[62:52]};
        job.ey = (ay[62:52] == 11'd0) ? 12'd1 : {1'b0, ay[62:52]};
        if (ax >= EXP_INF || ay > EXP_INF || ay == 63'd0)
        begin
            job.direct = 1'b1;
            job.direct_bits = QNAN_BITS;
            job.invalid = 1'b1;
        end
        else if (ay == EXP_INF || ax == 63'd0 || ay > ax)
        begin
            job.direct = 1'b1;
            job.direct_bits = operands.dividend_bits;
        end
        else if (ax == ay)
        begin
            job.direct = 1'b1;
            job.direct_bits = {sx, 63'd0};
        end
    end
endmodule

@@ design/dfm_queue.sv @@
// Short job queue between front and back end.
// Depends on dfm_pkg.
`timescale 1ns / 1ps
module dfm_queue #(
    parameter int DEPTH = dfm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfm_pkg::dfm_job_t wdata,
    input  logic              pop,
    output dfm_pkg::dfm_job_t rdata,
    output logic              full,
    output logic              empty
);
    import dfm_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dfm_job_t         mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

@@ design/dfm_back.sv @@
// Back end: normalize, shift-subtract reduction, renormalize, pack.
// Depends on dfm_pkg.
`timescale 1ns / 1ps
module dfm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  dfm_pkg::dfm_job_t job,
    output logic              pop,
    output logic              done,
    output dfm_pkg::dfm_out_t result
);
    import dfm_pkg::*;

    dfm_state_t       state_reg, state_next;
    logic [53:0]      mx_reg, mx_next;
    logic [52:0]      my_reg, my_next;
    logic signed [13:0] ex_reg, ex_next, ey_reg, ey_next;
    logic             sign_reg, sign_next;
    dfm_out_t         res_reg, res_next;
    logic             done_reg, done_next;

    logic [53:0]      diff;
    logic             ge;
    logic [13:0]      sh;
    logic [52:0]      sub_mant;

    assign diff = mx_reg - {1'b0, my_reg};
    assign ge   = (mx_reg >= {1'b0, my_reg});
    assign sh   = 14'sd1 - ey_reg;
    assign sub_mant = (sh < 14'd64) ? (mx_reg[52:0] >> sh[5:0]) : '0;
    assign pop    = (state_reg == ST_IDLE) && !q_empty;
    assign done   = done_reg;
    assign result = res_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = job.direct ? ST_DONE : ST_NORM;
            ST_NORM:   if (mx_reg[52] && my_reg[52]) state_next = ST_REDUCE;
            ST_REDUCE: if (ex_reg == ey_reg) state_next = ST_RENORM;
            ST_RENORM: if (mx_reg == '0 || mx_reg[52]) state_next = ST_PACK;
            ST_PACK:   state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        mx_next = mx_reg;
        my_next = my_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        sign_next = sign_reg;
        res_next = res_reg;
        done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    mx_next = {1'b0, job.mx};
                    my_next = job.my;
                    ex_next = 14'(signed'({2'b0, job.ex}));
                    ey_next = 14'(signed'({2'b0, job.ey}));
                    sign_next = job.sign;
                    res_next.remainder_bits = job.direct_bits;
                    res_next.invalid_op = job.invalid;
                end
            end
            ST_NORM:
            begin
                // one bit per cycle toward hidden-bit position
                if (!mx_reg[52])
                begin
                    mx_next = mx_reg << 1;
                    ex_next = ex_reg - 14'sd1;
                end
                if (!my_reg[52])
                begin
                    my_next = my_reg << 1;
                    ey_next = ey_reg - 14'sd1;
                end
            end
            ST_REDUCE:
            begin
                if (ex_reg == ey_reg)
                    mx_next = ge ? diff : mx_reg;
                else
                begin
                    mx_next = (ge ? diff : mx_reg) << 1;
                    ex_next = ex_reg - 14'sd1;
                end
            end
            ST_RENORM:
            begin
                if (mx_reg != '0 && !mx_reg[52])
                begin
                    mx_next = mx_reg << 1;
                    ey_next = ey_reg - 14'sd1;
                end
            end
            ST_PACK:
            begin
                res_next.invalid_op = 1'b0;
                if (mx_reg == '0)
                    res_next.remainder_bits = {sign_reg, 63'd0};
                else if (ey_reg >= 14'sd1)
                    res_next.remainder_bits = {sign_reg, ey_reg[10:0], mx_reg[51:0]};
                else
                    res_next.remainder_bits = {sign_reg, 10'd0, sub_mant};
            end
            ST_DONE:   done_next = 1'b1;
            default:   ;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg <= mx_next;
        my_reg <= my_next;
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        sign_reg <= sign_next;
        res_reg <= res_next;
    end
endmodule

@@ design/double_fmod_shift_subtract.sv @@
// Double fmod: from accept to done a word passes operand normalize shifts, the
// shift-subtract reduction and renormalize shifts; special cases skip them.
// The back end holds one word at a time, one reduction step per cycle. A
// two-entry queue holds classified words; busy rises when it is full. done
// strobes one cycle per result and cannot be stalled.
// rst_n clears control asynchronously.
`timescale 1ns / 1ps
`include "double_fmod_shift_subtract_macros.svh"
module double_fmod_shift_subtract #(
    parameter int QDEPTH = dfm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dfm_pkg::dfm_in_t  operands,
    output logic              busy,
    output logic              done,
    output dfm_pkg::dfm_out_t result
);
    import dfm_pkg::*;

    dfm_job_t f_job, q_job;
    logic     push, pop, q_full, q_empty;

    dfm_front u_front (
        .start(start), .operands(operands),
        .q_full(q_full), .busy(busy), .push(push), .job(f_job)
    );

    dfm_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_job), .pop(pop),
        .rdata(q_job), .full(q_full), .empty(q_empty)
    );

    dfm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .job(q_job),
        .pop(pop), .done(done), .result(result)
    );

    `DFM_ASSERT_IMPL(a_no_push_full, clk, rst_n, q_full, !push)
    `DFM_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_empty, !pop)
    `DFM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
endmodule
